[src/hsfc_pkg.sv]
// Shared types and constants for the half/single float converter.
// No dependencies; imported by every design and testbench module.
package hsfc_pkg;

	localparam logic CMD_H2S = 1'b0;
	localparam logic CMD_S2H = 1'b1;

	localparam logic [1:0] RM_NEAREST = 2'd0;
	localparam logic [1:0] RM_DOWN    = 2'd1;
	localparam logic [1:0] RM_UP      = 2'd2;
	localparam logic [1:0] RM_TRUNC   = 2'd3;

	localparam logic [7:0] SGL_EXP_MAX   = 8'hFF;
	localparam logic [4:0] HLF_EXP_MAX   = 5'h1F;
	localparam logic [4:0] HLF_EXP_CLAMP = 5'd30;
	localparam logic [9:0] HLF_FRAC_MAX  = 10'h3FF;
	localparam logic [9:0] HLF_QNAN_BIT  = 10'h200;
	localparam logic [7:0] H2S_BIAS_ADJ  = 8'd112;
	localparam logic [7:0] H2S_SUB_BASE  = 8'd103;
	localparam logic [4:0] SGL_FRAC_W    = 5'd23;
	localparam logic [9:0] S2H_TINY_LIM  = 10'd113;
	localparam logic [9:0] S2H_ZERO_LIM  = 10'd96;
	localparam logic [9:0] S2H_OVF_LIM   = 10'd142;
	localparam logic [9:0] S2H_BIAS_ADJ  = 10'd112;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_TINY,
		KIND_SUB
	} kind_t;

	typedef struct packed {
		logic        sign;
		logic [7:0]  ex;
		logic        fr_nz;
		logic [9:0]  lo10;
		logic [11:0] f12;
		logic        away;
		logic [1:0]  mode;
	} rnd_t;

endpackage

[src/half_single_float_convert_top.sv]
// Top level of the half/single float converter: three-stage pipeline.
// Depends on hsfc_pkg and hsfc_round.
// Throughput: one conversion per cycle; each stage holds independently on stall.
// Stages: decode and rounding add, normalize and classify, shift and assemble.
// Reset: arst_n clears all stage valid bits asynchronously.
module half_single_float_convert_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] operand_bits
	input  logic [2:0]  s_tuser,   // [0] cmd, [2:1] rounding_mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] result_bits
);
	import hsfc_pkg::*;

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;

	logic        cmd_s1;
	logic [31:0] bits_s1;
	logic [3:0]  msb_s1;
	rnd_t        rnd_s1;
	rnd_t        rnd_in;
	logic [3:0]  msb_in;

	logic        cmd_s2;
	kind_t       kind_s2;
	logic [31:0] base_s2;
	logic [10:0] mant_s2;
	logic [4:0]  sh_s2;

	kind_t       kind_c;
	logic [31:0] base_c;
	logic [10:0] mant_c;
	logic [4:0]  sh_c;

	logic [31:0] res_s3;
	logic [31:0] res_c;

	assign en3      = !v_s3 || m_tready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign m_tvalid = v_s3;
	assign m_tdata  = res_s3;

	hsfc_round u_round (
		.bits (s_tdata),
		.mode (s_tuser[2:1]),
		.rnd  (rnd_in)
	);

	always_comb begin
		msb_in = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (s_tdata[i]) begin
				msb_in = 4'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= s_tvalid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			cmd_s1  <= s_tuser[0];
			bits_s1 <= s_tdata;
			msb_s1  <= msb_in;
			rnd_s1  <= rnd_in;
		end
	end

	logic        h_sign;
	logic [4:0]  h_ex;
	logic [9:0]  h_fr;
	logic        carry;
	logic [10:0] fn;
	logic [9:0]  eb;
	logic [9:0]  tiny_sh;
	logic [9:0]  hf_nan;
	logic        clamp;

	always_comb begin
		h_sign  = bits_s1[15];
		h_ex    = bits_s1[14:10];
		h_fr    = bits_s1[9:0];
		carry   = rnd_s1.f12[11];
		fn      = carry ? rnd_s1.f12[11:1] : rnd_s1.f12[10:0];
		eb      = {2'd0, rnd_s1.ex} + {9'd0, carry};
		tiny_sh = S2H_BIAS_ADJ - eb;
		hf_nan  = (rnd_s1.fr_nz && (rnd_s1.lo10 == 10'd0)) ? HLF_QNAN_BIT : rnd_s1.lo10;
		clamp   = ((rnd_s1.mode == RM_DOWN) && !rnd_s1.sign)
			|| ((rnd_s1.mode == RM_UP) && rnd_s1.sign)
			|| (rnd_s1.mode == RM_TRUNC);
		kind_c  = KIND_PLAIN;
		base_c  = 32'd0;
		mant_c  = 11'd0;
		sh_c    = 5'd0;
		if (cmd_s1 == CMD_H2S) begin
			if (h_ex == 5'd0) begin
				base_c = {h_sign, 31'd0};
				if (h_fr != 10'd0) begin
					kind_c = KIND_SUB;
					base_c = {h_sign, H2S_SUB_BASE + {4'd0, msb_s1}, 23'd0};
					mant_c = {1'b0, h_fr};
					sh_c   = SGL_FRAC_W - {1'b0, msb_s1};
				end
			end else if (h_ex == HLF_EXP_MAX) begin
				base_c = {h_sign, SGL_EXP_MAX, h_fr, 13'd0};
			end else begin
				base_c = {h_sign, {3'd0, h_ex} + H2S_BIAS_ADJ, h_fr, 13'd0};
			end
		end else begin
			if (rnd_s1.ex == 8'd0) begin
				base_c = {16'd0, rnd_s1.sign, 14'd0, rnd_s1.fr_nz && rnd_s1.away};
			end else if (rnd_s1.ex == SGL_EXP_MAX) begin
				base_c = {16'd0, rnd_s1.sign, HLF_EXP_MAX, hf_nan};
			end else if (eb < S2H_TINY_LIM) begin
				if (rnd_s1.away) begin
					base_c = {16'd0, rnd_s1.sign, 5'd0, 10'd1};
				end else if (eb <= S2H_ZERO_LIM) begin
					base_c = {16'd0, rnd_s1.sign, 15'd0};
				end else begin
					kind_c = KIND_TINY;
					base_c = {16'd0, rnd_s1.sign, 15'd0};
					mant_c = fn;
					sh_c   = tiny_sh[4:0];
				end
			end else if (eb > S2H_OVF_LIM) begin
				if (clamp) begin
					base_c = {16'd0, rnd_s1.sign, HLF_EXP_CLAMP, HLF_FRAC_MAX};
				end else begin
					base_c = {16'd0, rnd_s1.sign, HLF_EXP_MAX, 10'd0};
				end
			end else begin
				base_c = {16'd0, rnd_s1.sign, 5'(eb - S2H_BIAS_ADJ), fn[9:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			cmd_s2  <= cmd_s1;
			kind_s2 <= kind_c;
			base_s2 <= base_c;
			mant_s2 <= mant_c;
			sh_s2   <= sh_c;
		end
	end

	logic [10:0] tiny_f;
	logic [32:0] sub_f;

	always_comb begin
		tiny_f = mant_s2 >> sh_s2;
		sub_f  = {22'd0, mant_s2} << sh_s2;
		case (kind_s2)
			KIND_TINY: res_c = base_s2 | {22'd0, tiny_f[9:0]};
			KIND_SUB:  res_c = base_s2 | {9'd0, sub_f[22:0]};
			default:   res_c = base_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			res_s3 <= res_c;
		end
	end

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted transfer did not reach stage 1");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en2 |=> v_s1 && $stable(bits_s1))
		else $error("stage 1 changed while stalled");

	a_half_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && (cmd_s2 == CMD_S2H) |-> base_s2[31:16] == 16'd0)
		else $error("half result has upper bits set");

	a_tiny_only_s2h: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && (kind_s2 == KIND_TINY) |-> cmd_s2 == CMD_S2H)
		else $error("tiny shift on a widening conversion");

	a_sub_only_h2s: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && (kind_s2 == KIND_SUB) |-> cmd_s2 == CMD_H2S)
		else $error("subnormal shift on a narrowing conversion");

endmodule

[src/hsfc_round.sv]
// Single-to-half front end: field split and rounding increment of the mantissa.
// Depends on hsfc_pkg.
module hsfc_round (
	input  logic [31:0]       bits,
	input  logic [1:0]        mode,
	output hsfc_pkg::rnd_t    rnd
);
	import hsfc_pkg::*;

	logic        sign;
	logic [22:0] fr;
	logic [12:0] r;
	logic        inc;

	assign sign = bits[31];
	assign fr   = bits[22:0];
	assign r    = fr[12:0];

	always_comb begin
		case (mode)
			RM_NEAREST: inc = r[12];
			RM_DOWN:    inc = (r != 13'd0) && sign;
			RM_UP:      inc = (r != 13'd0) && !sign;
			default:    inc = 1'b0;
		endcase
	end

	always_comb begin
		rnd.sign  = sign;
		rnd.ex    = bits[30:23];
		rnd.fr_nz = (fr != 23'd0);
		rnd.lo10  = fr[9:0];
		rnd.f12   = {1'b0, 1'b1, fr[22:13]} + {11'd0, inc};
		rnd.away  = ((mode == RM_DOWN) && sign) || ((mode == RM_UP) && !sign);
		rnd.mode  = mode;
	end

endmodule

[tb/sv/hsfc_checker.sv]
`timescale 1ns / 1ps
// Result checker for half_single_float_convert_top: predicts each conversion
// at input transfer and compares output transfers in order. Depends on hsfc_pkg.
module hsfc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	output int          fail_count,
	output int          pending
);
	import hsfc_pkg::*;

	logic [31:0] expected_results[$];

	function automatic logic [31:0] widen_half_to_single(logic [15:0] h);
		logic [4:0]  ex;
		logic [9:0]  fr;
		logic [7:0]  oe;
		logic [22:0] of;
		int          msb;
		ex = h[14:10];
		fr = h[9:0];
		of = {fr, 13'd0};
		if (ex == 5'd0) begin
			oe = 8'd0;
			if (fr != 10'd0) begin
				msb = 9;
				while (!fr[msb])
					msb--;
				oe = H2S_SUB_BASE + 8'(msb);
				of = 23'(33'(fr) << (23 - msb));
			end
		end else if (ex == HLF_EXP_MAX) begin
			oe = SGL_EXP_MAX;
		end else begin
			oe = {3'd0, ex} + H2S_BIAS_ADJ;
		end
		return {h[15], oe, of};
	endfunction

	function automatic logic [15:0] narrow_single_to_half(logic [31:0] v, logic [1:0] rm);
		logic        sgn;
		logic [7:0]  ex;
		logic [22:0] fr;
		logic        away;
		int          e;
		int          sh;
		logic [11:0] f;
		logic [12:0] r;
		logic [9:0]  hf;
		logic [4:0]  he;
		sgn  = v[31];
		ex   = v[30:23];
		fr   = v[22:0];
		away = (rm == RM_DOWN && sgn) || (rm == RM_UP && !sgn);
		if (ex == 8'd0)
			return {sgn, 14'd0, (fr != 23'd0) && away};
		if (ex == SGL_EXP_MAX) begin
			hf = fr[9:0];
			if (fr != 23'd0 && hf == 10'd0)
				hf = HLF_QNAN_BIT;
			return {sgn, HLF_EXP_MAX, hf};
		end
		e = int'(ex) - 127;
		f = {2'b01, fr[22:13]};
		r = fr[12:0];
		case (rm)
			RM_NEAREST: if (r >= 13'h1000) f++;
			RM_DOWN:    if (r != 13'd0 && sgn) f++;
			RM_UP:      if (r != 13'd0 && !sgn) f++;
			default: ;
		endcase
		if (f > 12'h7FF) begin
			e++;
			f = f >> 1;
		end
		if (e < -14) begin
			sh = -15 - e;
			f  = (sh >= 16) ? 12'd0 : (f >> sh);
			if (away)
				f = 12'd1;
			hf = f[9:0];
			he = 5'd0;
		end else if (e > 15) begin
			if ((rm == RM_DOWN && !sgn) || (rm == RM_UP && sgn) || rm == RM_TRUNC) begin
				hf = HLF_FRAC_MAX;
				he = HLF_EXP_CLAMP;
			end else begin
				hf = 10'd0;
				he = HLF_EXP_MAX;
			end
		end else begin
			hf = f[9:0];
			he = 5'(e + 15);
		end
		return {sgn, he, hf};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			expected_results.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == CMD_H2S)
					expected_results.push_back(widen_half_to_single(s_tdata[15:0]));
				else
					expected_results.push_back({16'd0,
						narrow_single_to_half(s_tdata, s_tuser[2:1])});
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result_bits: unexpected transfer, actual %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata !== want) begin
						$error("result_bits mismatch: expected %h actual %h", want, m_tdata);
						fail_count++;
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the half/single float converter testbench: clock, reset, stimulus
// with random idling on both channels, and the verdict. Depends on hsfc_pkg, hsfc_checker.
module testbench;
	import hsfc_pkg::*;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = 32'd0;  // [31:0] operand_bits
	logic [2:0]  s_tuser  = 3'd0;   // [0] cmd, [2:1] rounding_mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // [31:0] result_bits

	int fail_count;
	int pending;
	bit steady = 1'b0;
	int rx_hold = 0;

	half_single_float_convert_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hsfc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// stall the result side at random
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold == 0) begin
				m_tready <= 1'b1;
				if (!steady)
					rx_hold = pick_gap();
			end else begin
				m_tready <= 1'b0;
				rx_hold--;
			end
		end
	end

	task automatic send(input logic cmd, input logic [31:0] bits, input logic [1:0] rm);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= bits;
		s_tuser  <= {rm, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// hold off the sender until every result is back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic        cmd;
		logic [1:0]  rm;
		logic [31:0] bits;
		int          sel;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		send(CMD_H2S, 32'h0000_0000, RM_NEAREST);
		send(CMD_H2S, 32'hABCD_8000, RM_UP);
		send(CMD_H2S, 32'h0000_0001, RM_NEAREST);
		send(CMD_H2S, 32'hFFFF_83FF, RM_DOWN);
		send(CMD_H2S, 32'h0000_7BFF, RM_TRUNC);
		send(CMD_H2S, 32'h0000_FC00, RM_NEAREST);
		send(CMD_H2S, 32'h0000_7C01, RM_NEAREST);
		send(CMD_S2H, 32'h0000_0000, RM_NEAREST);
		send(CMD_S2H, 32'h807F_FFFF, RM_DOWN);
		send(CMD_S2H, 32'h0000_0001, RM_UP);
		send(CMD_S2H, 32'h0000_0001, RM_DOWN);
		send(CMD_S2H, 32'h7F80_0000, RM_NEAREST);
		send(CMD_S2H, 32'hFF80_2000, RM_TRUNC);
		send(CMD_S2H, 32'h7FC0_0155, RM_NEAREST);
		send(CMD_S2H, 32'h3F80_1000, RM_NEAREST);
		send(CMD_S2H, 32'h3F80_0FFF, RM_NEAREST);
		send(CMD_S2H, 32'h477F_F000, RM_NEAREST);
		send(CMD_S2H, 32'h7F7F_FFFF, RM_TRUNC);
		send(CMD_S2H, 32'hFF7F_FFFF, RM_UP);
		send(CMD_S2H, 32'h7F7F_FFFF, RM_DOWN);
		send(CMD_S2H, 32'h7F7F_FFFF, RM_UP);
		send(CMD_S2H, 32'h3800_0000, RM_NEAREST);
		send(CMD_S2H, 32'h3380_0000, RM_UP);
		send(CMD_S2H, 32'h2F80_0000, RM_NEAREST);
		send(CMD_S2H, 32'hB8FF_FFFF, RM_DOWN);
		drain();

		for (int n = 0; n < 1000; n++) begin
			steady = (n >= 300 && n < 450);
			if (n == 600)
				drain();
			cmd  = 1'($urandom_range(0, 1));
			rm   = 2'($urandom_range(0, 3));
			bits = $urandom;
			sel  = $urandom_range(0, 99);
			if (cmd == CMD_S2H) begin
				// bias exponents toward the half range and its edges
				if (sel < 55)
					bits[30:23] = 8'($urandom_range(96, 145));
				else if (sel < 63)
					bits[30:23] = 8'd0;
				else if (sel < 71)
					bits[30:23] = SGL_EXP_MAX;
				sel = $urandom_range(0, 99);
				if (sel < 12)
					bits[12:0] = 13'h1000;
				else if (sel < 20)
					bits[12:0] = 13'h0000;
				else if (sel < 25)
					bits[12:0] = 13'h0FFF;
			end else begin
				if (sel < 20)
					bits[14:10] = 5'd0;
				else if (sel < 30)
					bits[14:10] = HLF_EXP_MAX;
			end
			send(cmd, bits, rm);
		end
		steady = 1'b0;

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("half_single_float_convert_top test passed");
		else
			$display("half_single_float_convert_top test failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("half_single_float_convert_top test failed");
		$finish;
	end

endmodule

[half_single_float_convert_top.f]
src/hsfc_pkg.sv
src/hsfc_round.sv
src/half_single_float_convert_top.sv
tb/sv/hsfc_checker.sv
tb/sv/testbench.sv
